// ===== rtl/vacbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vacbd_pkg
// Shared sizes, codes and types of the VA-file bound distance core.
// ----------------------------------------------------------------------------
package vacbd_pkg;

	// table geometry
	localparam int MAX_DIMS    = 128;
	localparam int CODE_BITS   = 4;
	localparam int NBOUNDS     = (1 << CODE_BITS) + 1;
	localparam int TABLE_DEPTH = MAX_DIMS * NBOUNDS;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int DCNT_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNT_W       = DCNT_W + 1;

	// datapath widths
	localparam int VAL_W  = 24;
	localparam int DIFF_W = VAL_W + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = 55;
	localparam int PIDX_W = 32;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// item kinds
	localparam logic [1:0] KIND_BOUND = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CODE  = 2'd2;

	// register index (paddr[2])
	localparam logic REG_NUM_DIMS = 1'b0;

	// per-dimension contributions to the two sums
	typedef struct packed {
		logic [SQ_W-1:0] add_lower;
		logic [SQ_W-1:0] add_upper;
	} term_t;

endpackage

// ===== rtl/vacbd_bound_term.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vacbd_bound_term
// Squared distances from the query to both cell boundaries and the choice of
// which one feeds the lower and the upper sum.
// ----------------------------------------------------------------------------
module vacbd_bound_term (
	input  logic signed [vacbd_pkg::VAL_W-1:0] q,
	input  logic signed [vacbd_pkg::VAL_W-1:0] lo,
	input  logic signed [vacbd_pkg::VAL_W-1:0] hi,
	output vacbd_pkg::term_t                   term
);

	logic signed [vacbd_pkg::DIFF_W-1:0] d_lo;
	logic signed [vacbd_pkg::DIFF_W-1:0] d_hi;
	logic        [vacbd_pkg::DIFF_W-1:0] m_lo;
	logic        [vacbd_pkg::DIFF_W-1:0] m_hi;
	logic        [vacbd_pkg::SQ_W-1:0]   t_lo;
	logic        [vacbd_pkg::SQ_W-1:0]   t_hi;
	logic signed [vacbd_pkg::DIFF_W:0]   d_lo_x;
	logic signed [vacbd_pkg::DIFF_W:0]   n_hi_x;
	logic below;
	logic above;
	logic far_lo;

	// signed differences and their magnitudes
	assign d_lo = vacbd_pkg::DIFF_W'(q) - vacbd_pkg::DIFF_W'(lo);
	assign d_hi = vacbd_pkg::DIFF_W'(q) - vacbd_pkg::DIFF_W'(hi);
	assign m_lo = d_lo[vacbd_pkg::DIFF_W-1] ? vacbd_pkg::DIFF_W'(-d_lo) : d_lo;
	assign m_hi = d_hi[vacbd_pkg::DIFF_W-1] ? vacbd_pkg::DIFF_W'(-d_hi) : d_hi;

	// one multiplier per boundary
	assign t_lo = m_lo * m_lo;
	assign t_hi = m_hi * m_hi;

	// position of the query against the cell
	assign below  = lo > q;
	assign above  = q > hi;
	assign d_lo_x = (vacbd_pkg::DIFF_W+1)'(d_lo);
	assign n_hi_x = -(vacbd_pkg::DIFF_W+1)'(d_hi);
	assign far_lo = d_lo_x > n_hi_x;

	always_comb begin
		if (below) begin
			term.add_lower = t_lo;
			term.add_upper = t_hi;
		end else if (above) begin
			term.add_lower = t_hi;
			term.add_upper = t_lo;
		end else begin
			// inside the cell: only the farther boundary counts, tie goes high
			term.add_lower = '0;
			term.add_upper = far_lo ? t_lo : t_hi;
		end
	end

endmodule

// ===== rtl/va_code_bound_distance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va_code_bound_distance_core
// VA-file lower and upper squared-distance bounds for a stream of cell codes.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the input is not stalled, loads and codes
// alike. Load words write the boundary table or the query store at the
// accept edge; code words read both boundaries and the query coordinate
// there, form the two squared distances in the next stage and add them into
// the running sums in the stage after, from where a point's result goes into
// the result register. The result register parts the two sides: words keep
// flowing while a result waits, and the input stalls only when a second
// point completes before the first result is taken. Boundaries and query
// coordinates must be loaded before codes use them; there is no clearing
// pass after reset. The user must write num_dims through the APB port only
// while the core is idle; the core itself has no check for this.
// ----------------------------------------------------------------------------
module va_code_bound_distance_core (
	input  logic                                clk,
	input  logic                                arst_n,

	// APB register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,

	// item channel
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [1:0]                          kind,
	input  logic [6:0]                          dim,
	input  logic [4:0]                          bound_index,
	input  logic signed [23:0]                  value,
	input  logic [3:0]                          code,

	// result channel
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [vacbd_pkg::PIDX_W-1:0]        point_index,
	output logic [vacbd_pkg::SUM_W-1:0]         lower_bound,
	output logic [vacbd_pkg::SUM_W-1:0]         upper_bound,
	output logic                                saturated
);

	localparam int VW = vacbd_pkg::VAL_W;
	localparam int AW = vacbd_pkg::ADDR_W;
	localparam int DW = vacbd_pkg::DCNT_W;
	localparam int CW = vacbd_pkg::CNT_W;
	localparam int SW = vacbd_pkg::SUM_W;

	// register file
	logic [7:0] num_dims_q;
	logic       cfg_wr;

	// stores
	logic signed [VW-1:0] bound_mem [vacbd_pkg::TABLE_DEPTH];
	logic signed [VW-1:0] query_mem [vacbd_pkg::MAX_DIMS];

	// accept side
	logic          accept;
	logic          bound_we;
	logic          query_we;
	logic          code_rd;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr_lo;
	logic [AW-1:0] rd_addr_hi;
	logic [AW-1:0] row_base;
	logic [CW-1:0] eff_dims;
	logic [CW-1:0] cnt_next;
	logic          code_last;
	logic [DW-1:0] dim_cnt_q;

	// stage 1: store read data
	logic                 v_s1;
	logic                 last_s1;
	logic signed [VW-1:0] q_s1;
	logic signed [VW-1:0] lo_s1;
	logic signed [VW-1:0] hi_s1;

	// stage 2: terms
	logic             v_s2;
	logic             last_s2;
	vacbd_pkg::term_t term_c;
	vacbd_pkg::term_t term_s2;

	// accumulation
	logic [SW-1:0]                  lower_sum_q;
	logic [SW-1:0]                  upper_sum_q;
	logic                           sat_q;
	logic [vacbd_pkg::PIDX_W-1:0]   point_cnt_q;
	logic [SW:0]                    sum_lo_raw;
	logic [SW:0]                    sum_up_raw;
	logic [SW-1:0]                  sum_lo;
	logic [SW-1:0]                  sum_up;
	logic                           sat_now;

	// flow control
	logic adv_s1;
	logic adv_s2;
	logic take_s1;
	logic take_s2;
	logic emit;

	// ------------------------------------------------------------------
	// APB register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= 8'd1;
		end else if (cfg_wr && (paddr[2] == vacbd_pkg::REG_NUM_DIMS)) begin
			num_dims_q <= pwdata[7:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			vacbd_pkg::REG_NUM_DIMS: prdata = {24'd0, num_dims_q};
			default:                 prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// flow control: stages move unless a completed point meets a full
	// result register
	assign emit    = v_s2 && last_s2 && (!result_valid || result_ready);
	assign adv_s2  = v_s2 && (!last_s2 || !result_valid || result_ready);
	assign take_s2 = !v_s2 || adv_s2;
	assign adv_s1  = v_s1 && take_s2;
	assign take_s1 = !v_s1 || adv_s1;

	assign item_ready = take_s1;
	assign accept     = item_valid && item_ready;

	// ------------------------------------------------------------------
	// word decode
	always_comb begin
		bound_we = 1'b0;
		query_we = 1'b0;
		code_rd  = 1'b0;
		unique case (kind)
			vacbd_pkg::KIND_BOUND: begin
				bound_we = accept && (32'(dim) < vacbd_pkg::MAX_DIMS)
					&& (32'(bound_index) < vacbd_pkg::NBOUNDS);
			end
			vacbd_pkg::KIND_QUERY: begin
				query_we = accept && (32'(dim) < vacbd_pkg::MAX_DIMS);
			end
			vacbd_pkg::KIND_CODE: begin
				code_rd = accept;
			end
			default: ;
		endcase
	end

	// effective dimension count, clamped to 1..MAX_DIMS
	always_comb begin
		if (num_dims_q == 8'd0)
			eff_dims = CW'(1);
		else if (32'(num_dims_q) > vacbd_pkg::MAX_DIMS)
			eff_dims = CW'(vacbd_pkg::MAX_DIMS);
		else
			eff_dims = CW'(num_dims_q);
	end

	assign cnt_next  = CW'(dim_cnt_q) + CW'(1);
	assign code_last = cnt_next >= eff_dims;

	// table addresses: row of NBOUNDS entries per dimension
	assign wr_addr    = AW'(AW'(DW'(dim)) * AW'(vacbd_pkg::NBOUNDS) + AW'(bound_index));
	assign row_base   = AW'(AW'(dim_cnt_q) * AW'(vacbd_pkg::NBOUNDS));
	assign rd_addr_lo = AW'(row_base + AW'(code[vacbd_pkg::CODE_BITS-1:0]));
	assign rd_addr_hi = AW'(rd_addr_lo + AW'(1));

	// dimension counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_cnt_q <= '0;
		end else if (code_rd) begin
			dim_cnt_q <= code_last ? '0 : DW'(cnt_next);
		end
	end

	// ------------------------------------------------------------------
	// boundary table and query store, registered reads into stage 1
	always_ff @(posedge clk) begin
		if (bound_we)
			bound_mem[wr_addr] <= value;
		if (code_rd) begin
			lo_s1 <= bound_mem[rd_addr_lo];
			hi_s1 <= bound_mem[rd_addr_hi];
		end
	end

	always_ff @(posedge clk) begin
		if (query_we)
			query_mem[DW'(dim)] <= value;
		if (code_rd)
			q_s1 <= query_mem[dim_cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
		end else if (take_s1) begin
			v_s1    <= code_rd;
			last_s1 <= code_last;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: squared distances
	vacbd_bound_term u_term (
		.q    (q_s1),
		.lo   (lo_s1),
		.hi   (hi_s1),
		.term (term_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else if (take_s2) begin
			v_s2    <= adv_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			term_s2 <= term_c;
	end

	// ------------------------------------------------------------------
	// saturating accumulation
	assign sum_lo_raw = {1'b0, lower_sum_q} + (SW+1)'(term_s2.add_lower);
	assign sum_up_raw = {1'b0, upper_sum_q} + (SW+1)'(term_s2.add_upper);
	assign sum_lo     = sum_lo_raw[SW] ? vacbd_pkg::SUM_MAX : sum_lo_raw[SW-1:0];
	assign sum_up     = sum_up_raw[SW] ? vacbd_pkg::SUM_MAX : sum_up_raw[SW-1:0];
	assign sat_now    = sat_q || sum_lo_raw[SW] || sum_up_raw[SW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_sum_q <= '0;
			upper_sum_q <= '0;
			sat_q       <= 1'b0;
			point_cnt_q <= '0;
		end else if (adv_s2) begin
			if (last_s2) begin
				lower_sum_q <= '0;
				upper_sum_q <= '0;
				sat_q       <= 1'b0;
				point_cnt_q <= point_cnt_q + vacbd_pkg::PIDX_W'(1);
			end else begin
				lower_sum_q <= sum_lo;
				upper_sum_q <= sum_up;
				sat_q       <= sat_now;
			end
		end
	end

	// ------------------------------------------------------------------
	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			point_index <= point_cnt_q;
			lower_bound <= sum_lo;
			upper_bound <= sum_up;
			saturated   <= sat_now;
		end
	end

`ifndef SYNTHESIS
	// a saturated point leaves at least one sum pinned at full scale
	a_sat_pinned: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
			(lower_bound == vacbd_pkg::SUM_MAX) || (upper_bound == vacbd_pkg::SUM_MAX))
		else $error("saturated result without a full-scale sum");

	// a completed point shows up with the index it was counted under
	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> result_valid && (point_index == $past(point_cnt_q)))
		else $error("completed point not presented with its index");

	// a stalled stage 2 keeps its terms
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv_s2 |=> v_s2 && $stable(term_s2) && last_s2)
		else $error("stage 2 changed while stalled");

	// the accumulator only moves when stage 2 hands over a word
	a_sum_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(lower_sum_q) && $stable(upper_sum_q) && $stable(point_cnt_q))
		else $error("sums changed without a stage 2 transfer");
`endif

endmodule

// ===== bench/tb_va_code_bound_distance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_va_code_bound_distance_core
// Self-checking bench for the VA-file bound distance core.
// ----------------------------------------------------------------------------
// Loads boundary cells and query coordinates, streams cell codes under a
// range of dimension counts, and checks every point's lower and upper
// squared-distance sums against a cycle-free model of the core. Writes go in
// through the APB port only while the core is drained. The sender works in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_va_code_bound_distance_core;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         DRAIN_WAIT  = 8;
	localparam int         ITEM_TARGET = 1100;

	// one completed point as the core reports it
	typedef struct {
		bit [vacbd_pkg::PIDX_W-1:0] idx;
		bit [vacbd_pkg::SUM_W-1:0]  lb;
		bit [vacbd_pkg::SUM_W-1:0]  ub;
		bit                         sat;
	} point_bounds_t;

	// Tracks boundary cells, query coordinates and the running sums, and
	// holds the bounds each completed point must report.
	class bound_ledger;
		int            bnd[vacbd_pkg::TABLE_DEPTH];
		bit            bnd_known[vacbd_pkg::TABLE_DEPTH];
		int            qry[vacbd_pkg::MAX_DIMS];
		bit            qry_known[vacbd_pkg::MAX_DIMS];
		bit [63:0]     lo_acc;
		bit [63:0]     hi_acc;
		bit            sat_acc;
		int            dcnt;
		bit [31:0]     pcnt;
		bit [7:0]      ndims;
		point_bounds_t due_bounds[$];
		int            mismatches;

		function new();
			ndims = 8'd1;
		endfunction

		function void set_dims(bit [7:0] v);
			ndims = v;
		endfunction

		function int pending();
			return due_bounds.size();
		endfunction

		// saturating add into a 55-bit sum
		function bit [63:0] add_clip(bit [63:0] s, bit [63:0] t);
			bit [63:0] r;
			r = s + t;
			if (r > 64'(vacbd_pkg::SUM_MAX)) begin
				sat_acc = 1'b1;
				return 64'(vacbd_pkg::SUM_MAX);
			end
			return r;
		endfunction

		function bit [63:0] sq_term(int a, int b);
			longint d;
			d = longint'(a) - longint'(b);
			if (d < 0)
				d = -d;
			return d * d;
		endfunction

		function void take_word(bit [1:0] k, bit [6:0] d, bit [4:0] bi, bit [23:0] v,
				bit [3:0] c);
			int            eff;
			int            base;
			int            q;
			int            lo;
			int            hi;
			bit [63:0]     tlo;
			bit [63:0]     thi;
			point_bounds_t pt;
			case (k)
				vacbd_pkg::KIND_BOUND: begin
					if (int'(bi) < vacbd_pkg::NBOUNDS) begin
						bnd[int'(d) * vacbd_pkg::NBOUNDS + int'(bi)]       = int'($signed(v));
						bnd_known[int'(d) * vacbd_pkg::NBOUNDS + int'(bi)] = 1'b1;
					end
				end
				vacbd_pkg::KIND_QUERY: begin
					qry[d]       = int'($signed(v));
					qry_known[d] = 1'b1;
				end
				vacbd_pkg::KIND_CODE: begin
					eff = (ndims == 8'd0) ? 1 :
						((int'(ndims) > vacbd_pkg::MAX_DIMS) ? vacbd_pkg::MAX_DIMS :
						int'(ndims));
					base = dcnt * vacbd_pkg::NBOUNDS
						+ int'(c & 4'((1 << vacbd_pkg::CODE_BITS) - 1));
					q    = qry[dcnt];
					lo   = bnd[base];
					hi   = bnd[base + 1];
					tlo  = sq_term(q, lo);
					thi  = sq_term(q, hi);
					if (lo > q) begin
						lo_acc = add_clip(lo_acc, tlo);
						hi_acc = add_clip(hi_acc, thi);
					end else if (q > hi) begin
						lo_acc = add_clip(lo_acc, thi);
						hi_acc = add_clip(hi_acc, tlo);
					end else if (longint'(q) - lo > longint'(hi) - q) begin
						hi_acc = add_clip(hi_acc, tlo);
					end else begin
						// tie goes to the upper boundary's term
						hi_acc = add_clip(hi_acc, thi);
					end
					dcnt++;
					if (dcnt >= eff) begin
						pt.idx = pcnt;
						pt.lb  = lo_acc[vacbd_pkg::SUM_W-1:0];
						pt.ub  = hi_acc[vacbd_pkg::SUM_W-1:0];
						pt.sat = sat_acc;
						due_bounds.push_back(pt);
						pcnt++;
						lo_acc  = '0;
						hi_acc  = '0;
						sat_acc = 1'b0;
						dcnt    = 0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_bounds(bit [31:0] idx, bit [vacbd_pkg::SUM_W-1:0] lb,
				bit [vacbd_pkg::SUM_W-1:0] ub, bit s);
			point_bounds_t pt;
			if (due_bounds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result idx=%0d lb=%h ub=%h sat=%b",
						$realtime, idx, lb, ub, s);
				return;
			end
			pt = due_bounds.pop_front();
			if (pt.idx != idx || pt.lb != lb || pt.ub != ub || pt.sat != s) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: point mismatch", $realtime);
					$display("  expected idx=%0d lb=%h ub=%h sat=%b",
						pt.idx, pt.lb, pt.ub, pt.sat);
					$display("  actual   idx=%0d lb=%h ub=%h sat=%b", idx, lb, ub, s);
				end
			end
		endfunction
	endclass

	logic                             clk          = 1'b0;
	logic                             arst_n       = 1'b0;
	logic                             psel         = 1'b0;
	logic                             penable      = 1'b0;
	logic                             pwrite       = 1'b0;
	logic [2:0]                       paddr        = '0;
	logic [31:0]                      pwdata       = '0;
	logic [31:0]                      prdata;
	logic                             pready;
	logic                             item_valid   = 1'b0;
	logic                             item_ready;
	logic [1:0]                       kind         = '0;
	logic [6:0]                       dim          = '0;
	logic [4:0]                       bound_index  = '0;
	logic signed [23:0]               value        = '0;
	logic [3:0]                       code         = '0;
	logic                             result_valid;
	logic                             result_ready = 1'b0;
	logic [vacbd_pkg::PIDX_W-1:0]     point_index;
	logic [vacbd_pkg::SUM_W-1:0]      lower_bound;
	logic [vacbd_pkg::SUM_W-1:0]      upper_bound;
	logic                             saturated;

	bound_ledger sums;
	int          burst_left  = 0;
	int          items_taken = 0;
	int          dim_scale[vacbd_pkg::MAX_DIMS];
	int          rx_cycle    = 0;
	int          rx_mode     = 0;

	va_code_bound_distance_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.dim          (dim),
		.bound_index  (bound_index),
		.value        (value),
		.code         (code),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.point_index  (point_index),
		.lower_bound  (lower_bound),
		.upper_bound  (upper_bound),
		.saturated    (saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: check accepted words, stall on a changing pattern
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sums.check_bounds(point_index, lower_bound, upper_bound, saturated);
		rx_cycle++;
		if (rx_cycle % 400 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0:       result_ready <= 1'b1;
			1:       result_ready <= ($urandom_range(0, 3) != 0);
			2:       result_ready <= ((rx_cycle % 7) < 2);
			default: result_ready <= $urandom_range(0, 1);
		endcase
	end

	// per-dimension spacing for the generated cell grid
	function automatic int scale_of(int d);
		if (dim_scale[d] == 0)
			dim_scale[d] = $urandom_range(1, 1 << 19);
		return dim_scale[d];
	endfunction

	function automatic int pick_bound_value(int d, int i);
		int sel;
		int s;
		sel = $urandom_range(0, 99);
		s   = scale_of(d);
		if (sel < 10)
			return ($urandom_range(0, 1) != 0) ? -8388608 : 8388607;
		if (sel < 30)
			return int'($signed(24'($urandom)));
		return (i - 8) * s + int'($urandom_range(0, s / 2));
	endfunction

	function automatic int pick_query_value(int d);
		int sel;
		int s;
		sel = $urandom_range(0, 99);
		s   = scale_of(d);
		if (sel < 10)
			return ($urandom_range(0, 1) != 0) ? -8388608 : 8388607;
		if (sel < 25)
			return int'($signed(24'($urandom)));
		return int'($urandom_range(0, 18 * s)) - 9 * s;
	endfunction

	// drive one word, hold it until taken, then log it
	task automatic put_word(bit [1:0] k, bit [6:0] d, bit [4:0] bi, bit [23:0] v,
			bit [3:0] c);
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) :
				$urandom_range(1, 16);
		end
		burst_left--;
		item_valid  <= 1'b1;
		kind        <= k;
		dim         <= d;
		bound_index <= bi;
		value       <= v;
		code        <= c;
		do @(posedge clk); while (!item_ready);
		sums.take_word(k, d, bi, v, c);
		if (k == vacbd_pkg::KIND_QUERY || k == vacbd_pkg::KIND_CODE
				|| (k == vacbd_pkg::KIND_BOUND && int'(bi) < vacbd_pkg::NBOUNDS))
			items_taken++;
	endtask

	task automatic load_bound(int d, int i, int v);
		put_word(vacbd_pkg::KIND_BOUND, d[6:0], i[4:0], v[23:0], 4'($urandom));
	endtask

	task automatic load_query(int d, int v);
		put_word(vacbd_pkg::KIND_QUERY, d[6:0], 5'($urandom), v[23:0], 4'($urandom));
	endtask

	// code for the current dimension; fills in any cell entry not yet loaded
	task automatic send_code(bit [3:0] c);
		int d;
		int base;
		d    = sums.dcnt;
		base = d * vacbd_pkg::NBOUNDS + int'(c);
		if (!sums.qry_known[d])
			load_query(d, pick_query_value(d));
		if (!sums.bnd_known[base])
			load_bound(d, int'(c), pick_bound_value(d, int'(c)));
		if (!sums.bnd_known[base + 1])
			load_bound(d, int'(c) + 1, pick_bound_value(d, int'(c) + 1));
		put_word(vacbd_pkg::KIND_CODE, 7'($urandom), 5'($urandom), 24'($urandom), c);
	endtask

	// ignored kinds, ignored boundary slots, stray reloads
	task automatic noise_word();
		int d;
		int i;
		d = $urandom_range(0, vacbd_pkg::MAX_DIMS - 1);
		case ($urandom_range(0, 2))
			0: put_word(KIND_UNUSED, 7'($urandom), 5'($urandom), 24'($urandom),
				4'($urandom));
			1: put_word(vacbd_pkg::KIND_BOUND, d[6:0],
				5'($urandom_range(vacbd_pkg::NBOUNDS, 31)), 24'($urandom), 4'($urandom));
			default: begin
				if ($urandom_range(0, 1) != 0) begin
					load_query(d, pick_query_value(d));
				end else begin
					i = $urandom_range(0, vacbd_pkg::NBOUNDS - 1);
					load_bound(d, i, pick_bound_value(d, i));
				end
			end
		endcase
	endtask

	// hold the sender until every point is out and the pipe is empty
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sums.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_dims(int nd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {vacbd_pkg::REG_NUM_DIMS, 2'b00};
		pwdata  <= {24'd0, nd[7:0]};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sums.set_dims(nd[7:0]);
	endtask

	task automatic run_phase(int nd, int n_codes);
		wait_idle();
		write_dims(nd);
		for (int n = 0; n < n_codes; n++) begin
			if ($urandom_range(0, 9) == 0)
				noise_word();
			if ($urandom_range(0, 11) == 0)
				load_query(sums.dcnt, pick_query_value(sums.dcnt));
			send_code(4'($urandom));
		end
	endtask

	// phase length: whole points, sometimes leaving one point partly done
	function automatic int phase_codes(int nd);
		int eff;
		int n;
		eff = (nd == 0) ? 1 : ((nd > vacbd_pkg::MAX_DIMS) ? vacbd_pkg::MAX_DIMS : nd);
		n   = (eff > 16) ? eff : eff * $urandom_range(1, 6);
		if ($urandom_range(0, 7) == 0)
			n += $urandom_range(0, eff - 1);
		return n;
	endfunction

	initial begin
		int fixed_dims[6];
		int nd;
		sums       = new();
		fixed_dims = '{0, 128, 3, 255, 1, 7};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one point per code at the reset dimension count
		load_bound(0, 0, 0);
		load_bound(0, 1, 512);
		load_query(0, 256);
		send_code(4'd0);            // query at cell center
		load_query(0, 0);
		send_code(4'd0);            // query on lower boundary
		load_query(0, 512);
		send_code(4'd0);            // query on upper boundary
		load_query(0, -8388608);
		send_code(4'd0);            // query below cell
		load_query(0, 600);
		send_code(4'd0);            // query above cell
		load_bound(0, 15, -8388608);
		load_bound(0, 16, 8388607);
		load_query(0, 8388607);
		send_code(4'd15);           // widest cell, largest term
		put_word(KIND_UNUSED, 7'h7f, 5'h1f, 24'hffffff, 4'hf);
		put_word(vacbd_pkg::KIND_BOUND, 7'd0, 5'd17, 24'h123456, 4'd0);
		put_word(vacbd_pkg::KIND_BOUND, 7'd0, 5'd31, 24'h800000, 4'd0);
		send_code(4'd0);

		// dimension count lowered in the middle of a point
		wait_idle();
		write_dims(3);
		load_query(1, 5);
		load_bound(1, 0, -10);
		load_bound(1, 1, 10);
		send_code(4'd0);
		wait_idle();
		write_dims(1);
		send_code(4'd0);

		foreach (fixed_dims[p])
			run_phase(fixed_dims[p], phase_codes(fixed_dims[p]));
		while (items_taken < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0:       nd = 0;
				1, 2, 3: nd = $urandom_range(9, 24);
				default: nd = $urandom_range(1, 8);
			endcase
			run_phase(nd, phase_codes(nd));
		end
		wait_idle();

		if (sums.mismatches == 0 && sums.pending() == 0)
			$display("va_code_bound_distance_core regression: pass");
		else
			$display("va_code_bound_distance_core regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("va_code_bound_distance_core regression: fail");
		$finish;
	end

endmodule
